[rtl/byte_stack_with_value_delete_defines.svh]
// assertion helpers for the rtl
`ifndef BYTE_STACK_WITH_VALUE_DELETE_DEFINES_SVH
`define BYTE_STACK_WITH_VALUE_DELETE_DEFINES_SVH

// checked on every rising edge outside reset
`define BSVD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("bsvd assertion failed");

// condition that must never be seen outside reset
`define BSVD_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("bsvd forbidden condition seen");

`endif

[rtl/bsvd_pkg.sv]
package bsvd_pkg;

  localparam int DEPTH   = 16;
  localparam int LEVEL_W = $clog2(DEPTH + 1);
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W  = 5;

  typedef enum logic [1:0] {
    KIND_PUSH      = 2'd0,
    KIND_POP       = 2'd1,
    KIND_DEL_FIRST = 2'd2,
    KIND_DEL_ALL   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPORT
  } state_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic load;   // take the pushed byte
    logic shift;  // take the neighbor's byte (one step toward the bottom)
  } cell_cmd_t;

endpackage

[rtl/bsvd_cell.sv]
module bsvd_cell (
  input  logic                clk,
  input  bsvd_pkg::cell_cmd_t cmd,
  input  logic [7:0]          load_data,
  input  logic [7:0]          nbr_data,
  input  logic [7:0]          key,
  output logic [7:0]          data,
  output logic                match
);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data <= load_data;
    end else if (cmd.shift) begin
      data <= nbr_data;
    end
  end

  assign match = (data == key);

endmodule

[rtl/byte_stack_with_value_delete.sv]
// byte stack with delete by value: a lifo of bsvd_pkg::DEPTH bytes held in a row of cells,
// cell 0 being the bottom. an item is taken when start is high and busy is low; exactly
// one result per item comes back on the result ports for a single cycle with done high,
// and the receiver cannot stall it, so it must take the result in that cycle. push and pop
// go from idle straight to the report state, which raises done. the deletes walk a scan
// pointer up the stack, one entry per cycle: a matching entry is dropped by shifting every
// cell above it down one place, otherwise the pointer moves on; the scan ends when the
// pointer reaches the fill level or, for a delete of the first match, after one removal.
// busy stays high until the cycle after done. stored bytes need no reset; only entries
// below the fill level are ever read.
`include "byte_stack_with_value_delete_defines.svh"

module byte_stack_with_value_delete (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] kind,
  input  logic [7:0] value,
  output logic       busy,
  output logic       done,
  output logic [7:0] top_value,
  output logic [4:0] fill_level,
  output logic       is_empty,
  output logic       is_full,
  output logic       ignored
);

  localparam int DEPTH   = bsvd_pkg::DEPTH;
  localparam int LEVEL_W = bsvd_pkg::LEVEL_W;
  localparam int IDX_W   = bsvd_pkg::IDX_W;

  bsvd_pkg::state_t state, state_next;

  logic [LEVEL_W-1:0] level, level_next;   // bytes held
  logic [LEVEL_W-1:0] ptr, ptr_next;       // scan position during deletes
  logic               first, first_next;   // delete stops after one removal
  logic               ign, ign_next;
  logic [7:0]         key, key_next;       // byte to match

  // sequencer strobes toward the cells
  logic do_load;
  logic do_shift;

  logic [7:0]       cell_data [DEPTH];
  logic [DEPTH-1:0] cell_match;

  bsvd_pkg::kind_t op;
  assign op = bsvd_pkg::kind_t'(kind);

  logic             at_end;
  logic             hit;
  logic [IDX_W-1:0] top_idx;
  logic [LEVEL_W-1:0] level_m1;
  logic             quick_op;   // push or pop taken at this edge

  assign at_end   = (ptr >= level);
  assign hit      = cell_match[ptr[IDX_W-1:0]];
  assign level_m1 = level - LEVEL_W'(1);
  assign top_idx  = level_m1[IDX_W-1:0];
  assign quick_op = start && !busy &&
                    (op == bsvd_pkg::KIND_PUSH || op == bsvd_pkg::KIND_POP);

  // the cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bsvd_pkg::cell_cmd_t cmd;
    logic [7:0]          nbr;

    assign cmd = '{load:  do_load && (level == LEVEL_W'(i)),
                   shift: do_shift && (LEVEL_W'(i) >= ptr)};

    // the top cell has no upper neighbor; what it takes on a shift is never read
    if (i == DEPTH - 1) begin : g_top
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end

    bsvd_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .load_data (value),
      .nbr_data  (nbr),
      .key       (key),
      .data      (cell_data[i]),
      .match     (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsvd_pkg::ST_IDLE;
      level <= '0;
    end else begin
      state <= state_next;
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr   <= ptr_next;
    first <= first_next;
    ign   <= ign_next;
    key   <= key_next;
  end

  always_comb begin
    state_next = state;
    level_next = level;
    ptr_next   = ptr;
    first_next = first;
    ign_next   = ign;
    key_next   = key;
    do_load    = 1'b0;
    do_shift   = 1'b0;
    done       = 1'b0;
    unique case (state)
      bsvd_pkg::ST_IDLE: begin
        if (start) begin
          ign_next = 1'b0;
          key_next = value;
          ptr_next = '0;
          unique case (op)
            bsvd_pkg::KIND_PUSH: begin
              state_next = bsvd_pkg::ST_REPORT;
              if (level == LEVEL_W'(DEPTH)) begin
                ign_next = 1'b1;
              end else begin
                do_load    = 1'b1;
                level_next = level + LEVEL_W'(1);
              end
            end
            bsvd_pkg::KIND_POP: begin
              state_next = bsvd_pkg::ST_REPORT;
              if (level == '0) begin
                ign_next = 1'b1;
              end else begin
                level_next = level_m1;
              end
            end
            bsvd_pkg::KIND_DEL_FIRST: begin
              first_next = 1'b1;
              state_next = bsvd_pkg::ST_SCAN;
            end
            bsvd_pkg::KIND_DEL_ALL: begin
              first_next = 1'b0;
              state_next = bsvd_pkg::ST_SCAN;
            end
          endcase
        end
      end
      bsvd_pkg::ST_SCAN: begin
        priority if (at_end) begin
          state_next = bsvd_pkg::ST_REPORT;
        end else if (hit) begin
          // drop the entry at ptr; ptr stays put to check what slid into it
          do_shift   = 1'b1;
          level_next = level_m1;
          if (first) begin
            state_next = bsvd_pkg::ST_REPORT;
          end
        end else begin
          ptr_next = ptr + LEVEL_W'(1);
        end
      end
      bsvd_pkg::ST_REPORT: begin
        done       = 1'b1;
        state_next = bsvd_pkg::ST_IDLE;
      end
      default: begin
        state_next = bsvd_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy       = (state != bsvd_pkg::ST_IDLE);
  assign is_empty   = (level == '0);
  assign is_full    = (level == LEVEL_W'(DEPTH));
  assign top_value  = is_empty ? 8'd0 : cell_data[top_idx];
  assign fill_level = bsvd_pkg::FILL_W'(level);
  assign ignored    = ign;

  // the stack never overfills
  `BSVD_NEVER(a_level_range, clk, rst, level > LEVEL_W'(DEPTH))
  // push and pop report on the next cycle
  `BSVD_ASSERT(a_quick_ops, clk, rst, quick_op |=> done)
  // a result lasts one cycle and frees the block
  `BSVD_ASSERT(a_done_once, clk, rst, done |=> (!done && !busy))
  // a delete never grows the stack
  `BSVD_ASSERT(a_scan_shrinks, clk, rst, (state == bsvd_pkg::ST_SCAN) |=> (level <= $past(level)))

endmodule
